// ===== hdl/cps_pkg.sv =====
`default_nettype none
package cps_pkg;

	// CORDIC depth and widths.
	localparam int unsigned CordicSteps = 24;
	localparam int unsigned CordW = 48;
	localparam int unsigned AngW = 32;

	localparam logic signed [31:0] GainQ30 = 32'sd652032874;
	localparam logic signed [31:0] PiQ29 = 32'sd1686629713;
	localparam logic signed [15:0] TurnLimit = 16'sd25736;

	// Configuration register indexes.
	localparam logic [1:0] RegCenterX = 2'd0;
	localparam logic [1:0] RegCenterY = 2'd1;
	localparam logic [1:0] RegRadius = 2'd2;
	localparam logic [1:0] RegPhaseRate = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [14:0] RadiusReset = 15'd256;
	localparam logic [31:0] PhaseRateReset = 32'd333772;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [AngW-1:0] atan_turn(input logic [4:0] i);
		logic [AngW-1:0] a;
		begin
			case (i)
				5'd0: a = 32'd536870912;
				5'd1: a = 32'd316933406;
				5'd2: a = 32'd167458907;
				5'd3: a = 32'd85004756;
				5'd4: a = 32'd42667331;
				5'd5: a = 32'd21354465;
				5'd6: a = 32'd10679838;
				5'd7: a = 32'd5340245;
				5'd8: a = 32'd2670163;
				5'd9: a = 32'd1335087;
				5'd10: a = 32'd667544;
				5'd11: a = 32'd333772;
				5'd12: a = 32'd166886;
				5'd13: a = 32'd83443;
				5'd14: a = 32'd41722;
				5'd15: a = 32'd20861;
				5'd16: a = 32'd10430;
				5'd17: a = 32'd5215;
				5'd18: a = 32'd2608;
				5'd19: a = 32'd1304;
				5'd20: a = 32'd652;
				5'd21: a = 32'd326;
				5'd22: a = 32'd163;
				5'd23: a = 32'd81;
				default: a = '0;
			endcase
			return a;
		end
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		begin
			if (v > 18'sd32767)
				return 16'sh7FFF;
			else if (v < -18'sd32768)
				return 16'sh8000;
			else
				return v[15:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== hdl/circle_pursuit_steering.sv =====
`default_nettype none
// Circle pursuit steering: fully pipelined, one item accepted every cycle.
// Registers from the start transfer to the result transfer: phase product and fold,
// the rotation CORDIC, sum, differences and squares, the bearing CORDIC alongside
// the 17-stage square root, then heading error, turn-rate product and output register.
// busy is held low; the receiver cannot stall, results appear on done for one cycle.
// Reset clears valid bits and sets the configuration registers to their reset values.
module circle_pursuit_steering (
	input wire clk,
	input wire arst_n,
	input wire start,
	output logic busy,
	input wire cfg_we,
	input wire [1:0] cfg_index,
	input wire [31:0] cfg_data,
	input wire signed [15:0] pose_x,
	input wire signed [15:0] pose_y,
	input wire [15:0] heading,
	input wire [31:0] time_tick,
	output logic done,
	output logic signed [15:0] target_x,
	output logic signed [15:0] target_y,
	output logic [15:0] linear_speed,
	output logic signed [15:0] turn_rate
);

	localparam int unsigned Steps = cps_pkg::CordicSteps;
	localparam int unsigned W = cps_pkg::CordW;
	localparam int unsigned AW = cps_pkg::AngW;

	logic signed [15:0] center_x_q;
	logic signed [15:0] center_y_q;
	logic [14:0] radius_q;
	logic [31:0] phase_rate_q;

	assign busy = 1'b0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q <= cps_pkg::RadiusReset;
			phase_rate_q <= cps_pkg::PhaseRateReset;
		end else if (cfg_we) begin
			case (cfg_index)
				cps_pkg::RegCenterX: center_x_q <= cfg_data[15:0];
				cps_pkg::RegCenterY: center_y_q <= cfg_data[15:0];
				cps_pkg::RegRadius: radius_q <= cfg_data[14:0];
				cps_pkg::RegPhaseRate: phase_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: phase product and scaled radius.
	logic v_s1;
	logic [31:0] phase_s1;
	logic [46:0] rk_s1;
	logic signed [15:0] px_s1, py_s1;
	logic [15:0] hd_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		phase_s1 <= 32'(phase_rate_q * time_tick);
		rk_s1 <= 47'(radius_q * 32'(cps_pkg::GainQ30));
		px_s1 <= pose_x;
		py_s1 <= pose_y;
		hd_s1 <= heading;
	end

	// Stage 2: fold the phase into the right half-plane.
	logic v_s2, flip_s2;
	logic signed [AW:0] z_s2;
	logic signed [W-1:0] x0_s2;
	logic signed [15:0] px_s2, py_s2;
	logic [15:0] hd_s2;
	logic signed [AW:0] zs;
	always_comb begin
		zs = {phase_s1[31], phase_s1};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		x0_s2 <= W'($signed({1'b0, rk_s1}));
		px_s2 <= px_s1;
		py_s2 <= py_s1;
		hd_s2 <= hd_s1;
		if (zs > 33'sd1073741824) begin
			z_s2 <= zs - 33'sd2147483648;
			flip_s2 <= 1'b1;
		end else if (zs < -33'sd1073741824) begin
			z_s2 <= zs + 33'sd2147483648;
			flip_s2 <= 1'b1;
		end else begin
			z_s2 <= zs;
			flip_s2 <= 1'b0;
		end
	end

	// Rotation CORDIC, one micro-rotation per stage.
	logic rv [Steps+1];
	logic signed [W-1:0] rx [Steps+1];
	logic signed [W-1:0] ry [Steps+1];
	logic signed [AW:0] rz [Steps+1];
	logic rf [Steps+1];
	logic signed [15:0] rpx [Steps+1];
	logic signed [15:0] rpy [Steps+1];
	logic [15:0] rhd [Steps+1];
	always_comb begin
		rv[0] = v_s2;
		rx[0] = x0_s2;
		ry[0] = '0;
		rz[0] = z_s2;
		rf[0] = flip_s2;
		rpx[0] = px_s2;
		rpy[0] = py_s2;
		rhd[0] = hd_s2;
	end
	for (genvar i = 0; i < Steps; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv[i+1] <= 1'b0;
			else rv[i+1] <= rv[i];
		end
		always_ff @(posedge clk) begin
			rf[i+1] <= rf[i];
			rpx[i+1] <= rpx[i];
			rpy[i+1] <= rpy[i];
			rhd[i+1] <= rhd[i];
			if (rz[i] >= 0) begin
				rx[i+1] <= rx[i] - (ry[i] >>> i);
				ry[i+1] <= ry[i] + (rx[i] >>> i);
				rz[i+1] <= rz[i] - $signed({1'b0, cps_pkg::atan_turn(5'(i))});
			end else begin
				rx[i+1] <= rx[i] + (ry[i] >>> i);
				ry[i+1] <= ry[i] - (rx[i] >>> i);
				rz[i+1] <= rz[i] + $signed({1'b0, cps_pkg::atan_turn(5'(i))});
			end
		end
	end

	// Stage 3: round, unfold, add center, saturate.
	logic signed [W-1:0] ox_r, oy_r;
	logic signed [17:0] ox_c, oy_c;
	always_comb begin
		ox_r = (rx[Steps] + W'(64'sd1 <<< 29)) >>> 30;
		oy_r = (ry[Steps] + W'(64'sd1 <<< 29)) >>> 30;
		ox_c = rf[Steps] ? -ox_r[17:0] : ox_r[17:0];
		oy_c = rf[Steps] ? -oy_r[17:0] : oy_r[17:0];
	end
	logic v_s3;
	logic signed [15:0] tx_s3, ty_s3, px_s3, py_s3;
	logic [15:0] hd_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= rv[Steps];
	end
	always_ff @(posedge clk) begin
		tx_s3 <= cps_pkg::sat16(18'(center_x_q) + ox_c);
		ty_s3 <= cps_pkg::sat16(18'(center_y_q) + oy_c);
		px_s3 <= rpx[Steps];
		py_s3 <= rpy[Steps];
		hd_s3 <= rhd[Steps];
	end

	// Stage 4: differences.
	logic v_s4;
	logic signed [16:0] dx_s4, dy_s4;
	logic signed [15:0] tx_s4, ty_s4;
	logic [15:0] hd_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		dx_s4 <= 17'(tx_s3) - 17'(px_s3);
		dy_s4 <= 17'(ty_s3) - 17'(py_s3);
		tx_s4 <= tx_s3;
		ty_s4 <= ty_s3;
		hd_s4 <= hd_s3;
	end

	// Stage 5: squares and bearing CORDIC entry (left half-plane turned).
	logic v_s5, zero_s5;
	logic [33:0] sq_s5;
	logic signed [W-1:0] bx_s5, by_s5;
	logic [AW-1:0] bz_s5;
	logic signed [15:0] tx_s5, ty_s5;
	logic [15:0] hd_s5;
	logic signed [W-1:0] dxw, dyw;
	always_comb begin
		dxw = W'(dx_s4) <<< 24;
		dyw = W'(dy_s4) <<< 24;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		sq_s5 <= 34'(dx_s4 * dx_s4) + 34'(dy_s4 * dy_s4);
		zero_s5 <= (dx_s4 == '0) && (dy_s4 == '0);
		tx_s5 <= tx_s4;
		ty_s5 <= ty_s4;
		hd_s5 <= hd_s4;
		if (dx_s4 < 0) begin
			bx_s5 <= -dxw;
			by_s5 <= -dyw;
			bz_s5 <= 32'h8000_0000;
		end else begin
			bx_s5 <= dxw;
			by_s5 <= dyw;
			bz_s5 <= '0;
		end
	end

	// Square root of the squared distance, running beside the bearing.
	logic sq_v;
	logic [16:0] sq_root;
	logic [16:0] sq_side;
	cps_isqrt #(.InW(34), .SideW(17)) u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s5),
		.radicand(sq_s5),
		.side_in(17'd0),
		.out_valid(sq_v),
		.root(sq_root),
		.side_out(sq_side)
	);

	// Delay line so the root lines up with the end of the bearing CORDIC.
	// Empty slots carry zero.
	localparam int unsigned Gap = Steps - 17;
	logic [16:0] rd [Gap+1];
	always_comb rd[0] = sq_v ? (sq_root ^ sq_side) : '0;
	for (genvar g = 0; g < Gap; g++) begin : g_dly
		always_ff @(posedge clk) rd[g+1] <= rd[g];
	end

	// Vectoring CORDIC.
	logic bv [Steps+1];
	logic bzero [Steps+1];
	logic signed [W-1:0] bx [Steps+1];
	logic signed [W-1:0] by [Steps+1];
	logic [AW-1:0] bz [Steps+1];
	logic signed [15:0] btx [Steps+1];
	logic signed [15:0] bty [Steps+1];
	logic [15:0] bhd [Steps+1];
	always_comb begin
		bv[0] = v_s5;
		bzero[0] = zero_s5;
		bx[0] = bx_s5;
		by[0] = by_s5;
		bz[0] = bz_s5;
		btx[0] = tx_s5;
		bty[0] = ty_s5;
		bhd[0] = hd_s5;
	end
	for (genvar i = 0; i < Steps; i++) begin : g_vec
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) bv[i+1] <= 1'b0;
			else bv[i+1] <= bv[i];
		end
		always_ff @(posedge clk) begin
			bzero[i+1] <= bzero[i];
			btx[i+1] <= btx[i];
			bty[i+1] <= bty[i];
			bhd[i+1] <= bhd[i];
			if (by[i] >= 0) begin
				bx[i+1] <= bx[i] + (by[i] >>> i);
				by[i+1] <= by[i] - (bx[i] >>> i);
				bz[i+1] <= bz[i] + cps_pkg::atan_turn(5'(i));
			end else begin
				bx[i+1] <= bx[i] - (by[i] >>> i);
				by[i+1] <= by[i] + (bx[i] >>> i);
				bz[i+1] <= bz[i] - cps_pkg::atan_turn(5'(i));
			end
		end
	end

	// Stage 6: heading error and speed.
	logic v_s6;
	logic signed [31:0] err_s6;
	logic [15:0] spd_s6;
	logic signed [15:0] tx_s6, ty_s6;
	logic [AW-1:0] brg;
	logic [17:0] half;
	always_comb begin
		brg = bzero[Steps] ? '0 : bz[Steps];
		half = (18'(rd[Gap]) + 18'd1) >> 1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= bv[Steps];
	end
	always_ff @(posedge clk) begin
		err_s6 <= $signed(brg - {bhd[Steps], 16'd0});
		spd_s6 <= (half > 18'd65535) ? 16'hFFFF : half[15:0];
		tx_s6 <= btx[Steps];
		ty_s6 <= bty[Steps];
	end

	// Stage 7: turn-rate product.
	logic v_s7;
	logic signed [63:0] prod_s7;
	logic [15:0] spd_s7;
	logic signed [15:0] tx_s7, ty_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		prod_s7 <= 64'(err_s6) * 64'(cps_pkg::PiQ29);
		spd_s7 <= spd_s6;
		tx_s7 <= tx_s6;
		ty_s7 <= ty_s6;
	end

	// Output register: round, shift and clamp the turn rate.
	logic signed [63:0] tr;
	always_comb tr = (prod_s7 + (64'sd1 <<< 46)) >>> 47;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s7;
	end
	always_ff @(posedge clk) begin
		target_x <= tx_s7;
		target_y <= ty_s7;
		linear_speed <= spd_s7;
		if (tr > 64'(cps_pkg::TurnLimit))
			turn_rate <= cps_pkg::TurnLimit;
		else if (tr < -64'(cps_pkg::TurnLimit))
			turn_rate <= -cps_pkg::TurnLimit;
		else
			turn_rate <= tr[15:0];
	end

endmodule
`default_nettype wire

// ===== hdl/cps_isqrt.sv =====
`default_nettype none
// Pipelined integer square root, one result bit per stage.
// Sideband payload travels alongside the radicand unchanged.
module cps_isqrt #(
	parameter int unsigned InW = 34,
	parameter int unsigned SideW = 8
) (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire [InW-1:0] radicand,
	input wire [SideW-1:0] side_in,
	output logic out_valid,
	output logic [InW/2-1:0] root,
	output logic [SideW-1:0] side_out
);

	localparam int unsigned Steps = InW / 2;

	logic [Steps:0] vld_s1;
	logic [InW-1:0] rem_s1 [Steps+1];
	logic [Steps-1:0] res_s1 [Steps+1];
	logic [SideW-1:0] side_s1 [Steps+1];

	always_comb begin
		vld_s1[0] = in_valid;
		rem_s1[0] = radicand;
		res_s1[0] = '0;
		side_s1[0] = side_in;
	end

	// Each stage decides one bit of the root by trial subtraction.
	for (genvar k = 0; k < Steps; k++) begin : g_step
		localparam int unsigned Sh = 2 * (Steps - 1 - k);
		logic [InW+1:0] trial;
		logic [InW+1:0] cur;
		always_comb begin
			cur = {2'b00, rem_s1[k]};
			trial = ({2'b00, {{2{1'b0}}, res_s1[k]}, 2'b01} << Sh);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[k+1] <= 1'b0;
			end else begin
				vld_s1[k+1] <= vld_s1[k];
			end
		end
		always_ff @(posedge clk) begin
			side_s1[k+1] <= side_s1[k];
			if (cur >= trial) begin
				rem_s1[k+1] <= InW'(cur - trial);
				res_s1[k+1] <= {res_s1[k][Steps-2:0], 1'b1};
			end else begin
				rem_s1[k+1] <= rem_s1[k];
				res_s1[k+1] <= {res_s1[k][Steps-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s1[Steps];
	assign root = res_s1[Steps];
	assign side_out = side_s1[Steps];

endmodule
`default_nettype wire

// ===== tb/tb_circle_pursuit_steering.sv =====
`default_nettype none
module tb_circle_pursuit_steering;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned DrainCycles = 90;

	// One steering command, as the block returns it.
	typedef struct packed {
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic [15:0] speed;
		logic signed [15:0] turn;
	} steer_cmd_t;

	// Arctangent of 2^-i, in units of 2^-32 turn.
	localparam longint AtanStep [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic signed [15:0] pose_x = '0;
	logic signed [15:0] pose_y = '0;
	logic [15:0] heading = '0;
	logic [31:0] time_tick = '0;
	logic done;
	logic signed [15:0] target_x;
	logic signed [15:0] target_y;
	logic [15:0] linear_speed;
	logic signed [15:0] turn_rate;

	// Shadow copy of the configuration registers.
	logic signed [15:0] model_cx = '0;
	logic signed [15:0] model_cy = '0;
	logic [14:0] model_radius = cps_pkg::RadiusReset;
	logic [31:0] model_rate = cps_pkg::PhaseRateReset;

	steer_cmd_t pending_cmds[$];
	int unsigned err_count = 0;
	int unsigned sent_count = 0;
	int unsigned checked_count = 0;
	int unsigned cfg_count = 0;
	int unsigned cycle_count = 0;
	bit burst_mode = 1'b0;

	circle_pursuit_steering i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pose_x(pose_x), .pose_y(pose_y), .heading(heading), .time_tick(time_tick),
		.done(done), .target_x(target_x), .target_y(target_y),
		.linear_speed(linear_speed), .turn_rate(turn_rate)
	);

	always #5 clk = ~clk;

	// Pursuit point on the circle for a given time, saturated to 16 bits.
	function automatic void circle_target(input logic [31:0] tick,
			output logic signed [15:0] tx, output logic signed [15:0] ty);
		logic [31:0] phase;
		longint z, x, y, xs, ys, sx, sy;
		bit flip;
		begin
			phase = model_rate * tick;
			z = longint'($signed(phase));
			flip = 1'b0;
			if (z > 64'sd1073741824) begin
				z -= 64'sd2147483648;
				flip = 1'b1;
			end else if (z < -64'sd1073741824) begin
				z += 64'sd2147483648;
				flip = 1'b1;
			end
			x = longint'(model_radius) * 64'sd652032874;
			y = 0;
			for (int i = 0; i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= AtanStep[i];
				end else begin
					x += ys; y -= xs; z += AtanStep[i];
				end
			end
			x = (x + (64'sd1 << 29)) >>> 30;
			y = (y + (64'sd1 << 29)) >>> 30;
			if (flip) begin
				x = -x;
				y = -y;
			end
			sx = longint'(model_cx) + x;
			sy = longint'(model_cy) + y;
			tx = (sx > 32767) ? 16'sh7FFF : (sx < -32768) ? 16'sh8000 : sx[15:0];
			ty = (sy > 32767) ? 16'sh7FFF : (sy < -32768) ? 16'sh8000 : sy[15:0];
		end
	endfunction

	// Full command for one pose: target, half distance and steering rate.
	function automatic steer_cmd_t steer_command(input logic signed [15:0] px,
			input logic signed [15:0] py, input logic [15:0] hd, input logic [31:0] tick);
		steer_cmd_t c;
		longint dx, dy, x, y, xs, ys, err, turn;
		longint unsigned sq, res, bitv, spd;
		logic [31:0] z, diff;
		begin
			circle_target(tick, c.tx, c.ty);
			dx = longint'(c.tx) - longint'(px);
			dy = longint'(c.ty) - longint'(py);
			// Integer square root of the squared distance.
			sq = longint'(dx * dx) + longint'(dy * dy);
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > sq)
				bitv >>= 2;
			while (bitv != 0) begin
				if (sq >= res + bitv) begin
					sq -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			spd = (res + 1) >> 1;
			c.speed = (spd > 65535) ? 16'hFFFF : spd[15:0];
			// Bearing to the target by vectoring; zero when on the target.
			z = '0;
			if (dx != 0 || dy != 0) begin
				x = dx * 64'sd16777216;
				y = dy * 64'sd16777216;
				if (x < 0) begin
					x = -x; y = -y; z = 32'h8000_0000;
				end
				for (int i = 0; i < 24; i++) begin
					xs = x >>> i;
					ys = y >>> i;
					if (y >= 0) begin
						x += ys; y -= xs; z += 32'(AtanStep[i]);
					end else begin
						x -= ys; y += xs; z -= 32'(AtanStep[i]);
					end
				end
			end
			diff = z - {hd, 16'h0000};
			err = longint'($signed(diff));
			turn = (err * 64'sd1686629713 + (64'sd1 << 46)) >>> 47;
			if (turn > 25736)
				turn = 25736;
			if (turn < -25736)
				turn = -25736;
			c.turn = turn[15:0];
			return c;
		end
	endfunction

	// Cycle counter with a hard stop.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_cmds.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Compare every result transfer with the oldest expected command.
	always @(posedge clk) begin
		steer_cmd_t e;
		if (arst_n && done) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t: result with none expected: %0d %0d %0d %0d", $time,
					target_x, target_y, linear_speed, turn_rate);
				err_count++;
			end else begin
				e = pending_cmds.pop_front();
				checked_count++;
				if (target_x !== e.tx) begin
					$display("%0t: target_x expected %0d actual %0d", $time, e.tx, target_x);
					err_count++;
				end
				if (target_y !== e.ty) begin
					$display("%0t: target_y expected %0d actual %0d", $time, e.ty, target_y);
					err_count++;
				end
				if (linear_speed !== e.speed) begin
					$display("%0t: linear_speed expected %0d actual %0d", $time, e.speed,
						linear_speed);
					err_count++;
				end
				if (turn_rate !== e.turn) begin
					$display("%0t: turn_rate expected %0d actual %0d", $time, e.turn, turn_rate);
					err_count++;
				end
			end
		end
	end

	// Present one pose and wait for its transfer; then, outside burst mode, idle for a random gap.
	task automatic send_pose(input logic [15:0] px, input logic [15:0] py,
			input logic [15:0] hd, input logic [31:0] tick);
		int unsigned gap;
		begin
			start <= 1'b1;
			pose_x <= px;
			pose_y <= py;
			heading <= hd;
			time_tick <= tick;
			do
				@(posedge clk);
			while (busy);
			pending_cmds.push_back(steer_command(px, py, hd, tick));
			sent_count++;
			gap = burst_mode ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Let the pipeline empty, then write one register.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		begin
			start <= 1'b0;
			@(posedge clk);
			while (pending_cmds.size() != 0)
				@(posedge clk);
			repeat (DrainCycles) @(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
			cfg_we <= 1'b0;
			case (idx)
				cps_pkg::RegCenterX: model_cx = val[15:0];
				cps_pkg::RegCenterY: model_cy = val[15:0];
				cps_pkg::RegRadius: model_radius = val[14:0];
				cps_pkg::RegPhaseRate: model_rate = val;
				default: ;
			endcase
			cfg_count++;
		end
	endtask

	task automatic set_circle(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] r, input logic [31:0] rate);
		begin
			write_reg(cps_pkg::RegCenterX, cx);
			write_reg(cps_pkg::RegCenterY, cy);
			write_reg(cps_pkg::RegRadius, r);
			write_reg(cps_pkg::RegPhaseRate, rate);
		end
	endtask

	// Pose placed exactly on the current target point.
	task automatic send_on_target(input logic [15:0] hd, input logic [31:0] tick);
		logic signed [15:0] tx, ty;
		begin
			circle_target(tick, tx, ty);
			send_pose(tx, ty, hd, tick);
		end
	endtask

	// Poses after reset use the reset configuration.
	task automatic test_reset_values();
		begin
			send_pose(16'd0, 16'd0, 16'd0, 32'd0);
			send_pose(16'h0100, 16'd0, 16'd0, 32'd1024);
			send_pose(16'h8000, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF);
		end
	endtask

	// Field extremes, the robot on its target, and a saturated target.
	task automatic test_directed();
		begin
			send_pose(16'h7FFF, 16'h7FFF, 16'h0000, 32'd0);
			send_pose(16'h8000, 16'h8000, 16'h8000, 32'h8000_0000);
			send_pose(16'h7FFF, 16'h8000, 16'h4000, 32'h4000_0000);
			send_pose(16'h8000, 16'h7FFF, 16'hC000, 32'h0000_0001);
			set_circle(32'd0, 32'd0, 32'd0, 32'd0);
			send_pose(16'd0, 16'd0, 16'd0, 32'd5);
			send_pose(16'd0, 16'd0, 16'h1234, 32'd5);
			send_pose(16'd0, 16'd0, 16'h8000, 32'd5);
			set_circle(32'h7FFF, 32'h8000, 32'h7FFF, 32'h7FFF_FFFF);
			send_pose(16'd0, 16'd0, 16'd0, 32'd1);
			send_pose(16'h8000, 16'h7FFF, 16'hFFFF, 32'd3);
			send_on_target(16'h2000, 32'd77);
			set_circle(32'h8000, 32'h7FFF, 32'h7FFF, 32'h8000_0000);
			send_pose(16'h7FFF, 16'h8000, 16'h0001, 32'd1);
			send_pose(16'd0, 16'd0, 16'h7FFF, 32'hFFFF_FFFF);
			// Phase wrap with a negative rate, at quarter-turn boundaries.
			set_circle(32'd0, 32'd0, 32'd1000, 32'hC000_0000);
			for (int k = 0; k < 5; k++)
				send_pose(16'd50, 16'hFF00, 16'(k * 16'h3000), 32'(k));
		end
	endtask

	// Random poses over a series of random and extreme circle settings.
	task automatic test_random_sweep(input int unsigned phases, input int unsigned per_phase);
		logic [31:0] cx, cy, r, rate;
		int unsigned sel;
		begin
			for (int p = 0; p < phases; p++) begin
				sel = $urandom_range(0, 3);
				cx = (sel == 0) ? 32'h8000 : $urandom;
				cy = (sel == 1) ? 32'h7FFF : $urandom;
				r = (sel == 2) ? 32'h7FFF : (sel == 3) ? 32'd0 : $urandom_range(0, 4096);
				rate = $urandom;
				if (p % 2 == 0) begin
					cx = $urandom_range(0, 2000) - 1000;
					cy = $urandom_range(0, 2000) - 1000;
				end
				set_circle(cx, cy, r, rate);
				burst_mode = (p % 3 == 1);
				for (int k = 0; k < per_phase; k++) begin
					if ($urandom_range(0, 15) == 0)
						send_on_target(16'($urandom), $urandom);
					else if ($urandom_range(0, 1) == 0)
						send_pose(16'($urandom_range(0, 4000) - 2000 + cx[15:0]),
							16'($urandom_range(0, 4000) - 2000 + cy[15:0]),
							16'($urandom), $urandom);
					else
						send_pose(16'($urandom), 16'($urandom), 16'($urandom), $urandom);
				end
			end
			burst_mode = 1'b0;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_random_sweep(10, 45);
		start <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		$display("Sent %0d poses and checked %0d commands", sent_count, checked_count);
		$display("across %0d register writes, extremes and on-target cases included",
			cfg_count);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
